[rtl/tfp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, character codes and divisor constants of the telemetry field parser.
package tfp_pkg;

   // ASCII codes the parser looks for
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SIX   = 8'h36;
   localparam logic [7:0] CHAR_EIGHT = 8'h38;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Digit accumulator saturates past this magnitude
   localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

   localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

   // Roll and pitch are sent with this offset
   localparam logic signed [32:0] ATT_OFFSET = 33'sd1000;

   // Right shifts that go with the reciprocals below
   localparam int SHIFT_HOURS  = 43;
   localparam int SHIFT_TENTHS = 35;
   localparam int SHIFT_GEO    = 55;
   localparam int SHIFT_HUND   = 38;
   localparam int FSHIFT_MIN   = 18;
   localparam int FSHIFT_TENTH = 4;
   localparam int FSHIFT_GEO   = 24;
   localparam int FSHIFT_HUND  = 7;

   typedef enum logic [2:0] {
      KIND_UPTIME,
      KIND_VOLTS,
      KIND_CHARGE,
      KIND_LON,
      KIND_LAT,
      KIND_ROLL,
      KIND_PITCH,
      KIND_NET
   } kind_type;

   typedef enum logic [1:0] {
      PH_BLANK,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   // Closed field handed from the parser to the arithmetic pipeline
   typedef struct packed {
      kind_type    kind;
      logic        done;
      logic        negative;
      logic [31:0] magnitude;
      logic        overflowed;
   } job_type;

   // Per-item tag that rides along the arithmetic pipeline
   typedef struct packed {
      kind_type           kind;
      logic               done;
      logic signed [31:0] raw;
      logic               neg;
   } tag_type;

   // Divisor of the integer split for each kind
   function automatic logic [23:0] div_coarse(kind_type kind);
      logic [23:0] d;
      unique case (kind)
         KIND_UPTIME:          d = 24'd3600;
         KIND_VOLTS:           d = 24'd10;
         KIND_CHARGE:          d = 24'd1;
         KIND_LON, KIND_LAT:   d = 24'd10000000;
         KIND_ROLL, KIND_PITCH,
         KIND_NET:             d = 24'd100;
      endcase
      return d;
   endfunction

   // floor(2^shift / divisor) for the integer split
   function automatic logic [31:0] recip_coarse(kind_type kind);
      logic [31:0] m;
      unique case (kind)
         KIND_UPTIME:          m = 32'd2443359172;
         KIND_VOLTS,
         KIND_CHARGE:          m = 32'd3435973836;
         KIND_LON, KIND_LAT:   m = 32'd3602879701;
         KIND_ROLL, KIND_PITCH,
         KIND_NET:             m = 32'd2748779069;
      endcase
      return m;
   endfunction

   // Divisor of the second split: minutes for uptime, Q24 fraction otherwise
   function automatic logic [23:0] div_fine(kind_type kind);
      logic [23:0] d;
      unique case (kind)
         KIND_UPTIME: d = 24'd60;
         KIND_VOLTS, KIND_CHARGE, KIND_LON, KIND_LAT,
         KIND_ROLL, KIND_PITCH, KIND_NET: d = div_coarse(kind);
      endcase
      return d;
   endfunction

   // Reciprocal of the second split
   function automatic logic [24:0] recip_fine(kind_type kind);
      logic [24:0] m;
      unique case (kind)
         KIND_UPTIME:          m = 25'd4370;
         KIND_VOLTS,
         KIND_CHARGE:          m = 25'd26843545;
         KIND_LON, KIND_LAT:   m = 25'd28147497;
         KIND_ROLL, KIND_PITCH,
         KIND_NET:             m = 25'd21474836;
      endcase
      return m;
   endfunction

endpackage

[rtl/tfp_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the byte input and the field result.
interface tfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;

   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface tfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         field_kind;
   logic signed [31:0] raw_value;
   logic signed [55:0] scaled_value;
   logic signed [20:0] uptime_hours;
   logic signed [6:0]  uptime_minutes;
   logic signed [6:0]  uptime_seconds;
   logic               message_done;

   modport source (output valid, output field_kind, output raw_value, output scaled_value,
                   output uptime_hours, output uptime_minutes, output uptime_seconds,
                   output message_done, input ready);
   modport sink (input valid, input field_kind, input raw_value, input scaled_value,
                 input uptime_hours, input uptime_minutes, input uptime_seconds,
                 input message_done, output ready);
endinterface

[rtl/telemetry_field_parser_unit.sv]
`timescale 1ns / 1ps
// Telemetry field parser top level: byte parser, field register and result pipeline.
//
// Input channel (req_if): one ASCII byte per transfer, with last_byte marking
// the end of a message. 'S' opens a field, the next byte is its type digit and
// the rest is read as a decimal number (blanks, sign, digits, trailing text
// ignored), saturated to 32-bit signed.
// Result channel (rsp_if): one transfer per closed field of a known type, with
// raw value, Q24 scaled value and the uptime split; unknown or empty fields
// give nothing.
// Throughput: one byte per cycle unless a receiver stall fills the pipeline. The
// byte parser updates its state in the cycle of the transfer; a closed field then
// passes the field register and the eight-stage arithmetic pipeline, A to H.
// Reset clears the parser (no field open) and empties the pipeline.
// When the receiver stalls, results queue in the pipeline stages; bytes keep
// being taken until the field register and every stage hold a result.
module telemetry_field_parser_unit (
   input  logic      clock,
   input  logic      reset,
   tfp_req_if.sink   req_if,
   tfp_rsp_if.source rsp_if
);

   // Parser state
   logic               open_ff, open_in;
   logic               kseen_ff, kseen_in;
   logic [7:0]         kchar_ff, kchar_in;
   tfp_pkg::phase_type phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [31:0]        mag_ff, mag_in;
   logic               ovf_ff, ovf_in;

   // Field register toward the pipeline
   logic             job_vld_ff, job_vld_in;
   tfp_pkg::job_type job_ff, job_in;
   logic             job_ready;

   logic       accept;
   logic [7:0] chr;
   logic       last;
   logic       is_s;
   logic       is_digit;
   logic       is_blank;
   logic       is_sign;
   logic [35:0] acc;

   // Number state after feeding this byte
   tfp_pkg::phase_type f_phase;
   logic               f_neg;
   logic [31:0]        f_mag;
   logic               f_ovf;

   // Field state after this byte, before any close
   logic               p_kseen;
   logic [7:0]         p_kchar;
   tfp_pkg::phase_type p_phase;
   logic               p_neg;
   logic [31:0]        p_mag;
   logic               p_ovf;
   logic               known;
   logic               fire;

   assign chr      = req_if.byte_in;
   assign last     = req_if.last_byte;
   assign accept   = req_if.valid && req_if.ready;
   assign is_s     = (chr == tfp_pkg::CHAR_S);
   assign is_digit = (chr >= tfp_pkg::CHAR_ZERO) && (chr <= tfp_pkg::CHAR_NINE);
   assign is_blank = (chr == tfp_pkg::CHAR_SPACE)
                     || ((chr >= tfp_pkg::CHAR_TAB) && (chr <= tfp_pkg::CHAR_CR));
   assign is_sign  = (chr == tfp_pkg::CHAR_PLUS) || (chr == tfp_pkg::CHAR_MINUS);
   assign acc      = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1) + 36'(chr[3:0]);

   // Feed one byte to the number scanner
   always_comb begin
      f_phase = phase_ff;
      f_neg   = neg_ff;
      f_mag   = mag_ff;
      f_ovf   = ovf_ff;
      unique case (phase_ff)
         tfp_pkg::PH_BLANK: begin
            priority if (is_blank) begin
               f_phase = tfp_pkg::PH_BLANK;
            end else if (is_sign) begin
               f_neg   = (chr == tfp_pkg::CHAR_MINUS);
               f_phase = tfp_pkg::PH_SIGN;
            end else if (is_digit) begin
               f_phase = tfp_pkg::PH_DIGITS;
            end else begin
               f_phase = tfp_pkg::PH_DONE;
            end
         end
         tfp_pkg::PH_SIGN: begin
            f_phase = is_digit ? tfp_pkg::PH_DIGITS : tfp_pkg::PH_DONE;
         end
         tfp_pkg::PH_DIGITS: begin
            if (!is_digit) begin
               f_phase = tfp_pkg::PH_DONE;
            end
         end
         tfp_pkg::PH_DONE: begin
            f_phase = tfp_pkg::PH_DONE;
         end
      endcase
      // Accumulate the digit, flag overflow past 2^31
      if ((f_phase == tfp_pkg::PH_DIGITS) && is_digit && !ovf_ff) begin
         if (acc > tfp_pkg::MAG_LIMIT) begin
            f_ovf = 1'b1;
         end else begin
            f_mag = acc[31:0];
         end
      end
   end

   // Route the byte to the type character or the number
   always_comb begin
      p_kseen = kseen_ff;
      p_kchar = kchar_ff;
      p_phase = phase_ff;
      p_neg   = neg_ff;
      p_mag   = mag_ff;
      p_ovf   = ovf_ff;
      if (!is_s && open_ff) begin
         if (!kseen_ff) begin
            p_kchar = chr;
            p_kseen = 1'b1;
         end else begin
            p_phase = f_phase;
            p_neg   = f_neg;
            p_mag   = f_mag;
            p_ovf   = f_ovf;
         end
      end
      known = ((p_kchar >= tfp_pkg::CHAR_ZERO) && (p_kchar <= tfp_pkg::CHAR_SIX))
              || (p_kchar == tfp_pkg::CHAR_EIGHT);
      fire  = open_ff && p_kseen && known && (is_s || last);

      job_in.kind       = (p_kchar == tfp_pkg::CHAR_EIGHT) ? tfp_pkg::KIND_NET
                                                            : tfp_pkg::kind_type'(p_kchar[2:0]);
      job_in.done       = last;
      job_in.negative   = p_neg;
      job_in.magnitude  = p_mag;
      job_in.overflowed = p_ovf;
   end

   // Next parser state: restart on 'S', go idle after the last byte
   always_comb begin
      if (is_s || last) begin
         open_in  = is_s && !last;
         kseen_in = 1'b0;
         kchar_in = '0;
         phase_in = tfp_pkg::PH_BLANK;
         neg_in   = 1'b0;
         mag_in   = '0;
         ovf_in   = 1'b0;
      end else begin
         open_in  = open_ff;
         kseen_in = p_kseen;
         kchar_in = p_kchar;
         phase_in = p_phase;
         neg_in   = p_neg;
         mag_in   = p_mag;
         ovf_in   = p_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         kseen_ff <= 1'b0;
         kchar_ff <= '0;
         phase_ff <= tfp_pkg::PH_BLANK;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (accept) begin
         open_ff  <= open_in;
         kseen_ff <= kseen_in;
         kchar_ff <= kchar_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Hold a closed field until the pipeline takes it
   assign req_if.ready = !job_vld_ff || job_ready;
   assign job_vld_in   = accept ? fire : (job_vld_ff && !job_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         job_vld_ff <= 1'b0;
      end else begin
         job_vld_ff <= job_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   tfp_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_vld_ff),
      .job       (job_ff),
      .job_ready (job_ready),
      .rsp_if    (rsp_if)
   );

`ifndef SYNTH
   // A new field enters the register only with a byte transfer
   a_job_source: assert property (@(posedge clock) disable iff (reset)
      $rose(job_vld_ff) |-> $past(accept))
      else $error("field register loaded without a byte transfer");

   // The last byte of a message leaves no field open
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> !open_ff)
      else $error("field still open after last byte");

   // A waiting field holds until the pipeline takes it
   a_job_hold: assert property (@(posedge clock) disable iff (reset)
      (job_vld_ff && !job_ready) |=> (job_vld_ff && $stable(job_ff)))
      else $error("field register changed while waiting");
`endif

endmodule

[rtl/tfp_arith.sv]
`timescale 1ns / 1ps
// Eight-stage arithmetic pipeline: value, Q24 scaling and uptime split of a closed field.
module tfp_arith (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  tfp_pkg::job_type job,
   output logic             job_ready,
   tfp_rsp_if.source        rsp_if
);

   logic [7:0] vld_ff;
   logic [7:0] vld_in;
   logic [7:0] adv;

   // Stage A: saturated value, offset, magnitude
   tfp_pkg::tag_type   a_tag_ff, a_tag_in;
   logic [31:0]        a_m_ff, a_m_in;
   logic [31:0]        a_neg_mag;
   logic signed [31:0] a_val;
   logic signed [32:0] a_wide;
   logic [32:0]        a_abs;
   logic               a_att;

   // Stage B: reciprocal product of the integer split
   tfp_pkg::tag_type b_tag_ff;
   logic [31:0]      b_m_ff;
   logic [63:0]      b_prod_ff, b_prod_in;

   // Stage C: quotient estimate and its back product
   tfp_pkg::tag_type c_tag_ff;
   logic [31:0]      c_m_ff;
   logic [31:0]      c_e_ff, c_e_in;
   logic [31:0]      c_ed_ff, c_ed_in;
   logic [63:0]      c_shift;
   logic [55:0]      c_ed_full;

   // Stage D: corrected quotient and remainder
   tfp_pkg::tag_type d_tag_ff;
   logic [31:0]      d_q_ff, d_q_in;
   logic [23:0]      d_r_ff, d_r_in;
   logic [31:0]      d_r0;
   logic [31:0]      d_div;

   // Stage E: reciprocal product of the second split
   tfp_pkg::tag_type e_tag_ff;
   logic [31:0]      e_q_ff;
   logic [23:0]      e_r_ff;
   logic [48:0]      e_prod_ff, e_prod_in;

   // Stage F: second estimate and its back product
   tfp_pkg::tag_type f_tag_ff;
   logic [31:0]      f_q_ff;
   logic [23:0]      f_r_ff;
   logic [23:0]      f_e2_ff, f_e2_in;
   logic [47:0]      f_e2d_ff, f_e2d_in;
   logic [48:0]      f_shift;

   // Stage G: magnitudes of all results
   tfp_pkg::tag_type g_tag_ff;
   logic [55:0]      g_mag_ff, g_mag_in;
   logic [19:0]      g_hours_ff, g_hours_in;
   logic [5:0]       g_min_ff, g_min_in;
   logic [5:0]       g_sec_ff, g_sec_in;
   logic [47:0]      g_diff;
   logic [23:0]      g_frac;
   logic [23:0]      g_sec_full;

   // Stage H: signed result register
   logic [2:0]         out_kind_ff, out_kind_in;
   logic signed [31:0] out_raw_ff, out_raw_in;
   logic signed [55:0] out_scaled_ff, out_scaled_in;
   logic signed [20:0] out_hours_ff, out_hours_in;
   logic signed [6:0]  out_min_ff, out_min_in;
   logic signed [6:0]  out_sec_ff, out_sec_in;
   logic               out_done_ff, out_done_in;
   logic               h_up;
   logic [20:0]        h_hours;
   logic [6:0]         h_min;
   logic [6:0]         h_sec;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      adv[7] = !vld_ff[7] || rsp_if.ready;
      adv[6] = !vld_ff[6] || adv[7];
      adv[5] = !vld_ff[5] || adv[6];
      adv[4] = !vld_ff[4] || adv[5];
      adv[3] = !vld_ff[3] || adv[4];
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
   end

   assign job_ready = adv[0];
   assign vld_in    = (adv & {vld_ff[6:0], job_valid}) | (~adv & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage A: saturate, remove attitude offset, take magnitude
   always_comb begin
      a_neg_mag = ~job.magnitude + 32'd1;
      if (job.negative) begin
         a_val = job.overflowed ? tfp_pkg::INT32_MIN : signed'(a_neg_mag);
      end else begin
         a_val = (job.overflowed || job.magnitude[31]) ? tfp_pkg::INT32_MAX
                                                        : signed'(job.magnitude);
      end
      a_att  = (job.kind == tfp_pkg::KIND_ROLL) || (job.kind == tfp_pkg::KIND_PITCH);
      a_wide = 33'(a_val) - (a_att ? tfp_pkg::ATT_OFFSET : 33'sd0);
      a_abs  = a_wide[32] ? (~a_wide + 33'd1) : a_wide;
      a_m_in = a_abs[31:0];
      a_tag_in.kind = job.kind;
      a_tag_in.done = job.done;
      a_tag_in.raw  = a_val;
      a_tag_in.neg  = a_wide[32];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         a_tag_ff <= a_tag_in;
         a_m_ff   <= a_m_in;
      end
   end

   // Stage B: multiply by the reciprocal of the coarse divisor
   assign b_prod_in = 64'(a_m_ff) * 64'(tfp_pkg::recip_coarse(a_tag_ff.kind));

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         b_tag_ff  <= a_tag_ff;
         b_m_ff    <= a_m_ff;
         b_prod_ff <= b_prod_in;
      end
   end

   // Stage C: drop the fraction bits, multiply back by the divisor
   always_comb begin
      unique case (b_tag_ff.kind)
         tfp_pkg::KIND_UPTIME:   c_shift = b_prod_ff >> tfp_pkg::SHIFT_HOURS;
         tfp_pkg::KIND_VOLTS,
         tfp_pkg::KIND_CHARGE:   c_shift = b_prod_ff >> tfp_pkg::SHIFT_TENTHS;
         tfp_pkg::KIND_LON,
         tfp_pkg::KIND_LAT:      c_shift = b_prod_ff >> tfp_pkg::SHIFT_GEO;
         tfp_pkg::KIND_ROLL, tfp_pkg::KIND_PITCH,
         tfp_pkg::KIND_NET:      c_shift = b_prod_ff >> tfp_pkg::SHIFT_HUND;
      endcase
      c_e_in    = c_shift[31:0];
      c_ed_full = 56'(c_e_in) * 56'(tfp_pkg::div_coarse(b_tag_ff.kind));
      c_ed_in   = c_ed_full[31:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         c_tag_ff <= b_tag_ff;
         c_m_ff   <= b_m_ff;
         c_e_ff   <= c_e_in;
         c_ed_ff  <= c_ed_in;
      end
   end

   // Stage D: the estimate is at most one low; fix it up
   always_comb begin
      d_div = 32'(tfp_pkg::div_coarse(c_tag_ff.kind));
      d_r0  = c_m_ff - c_ed_ff;
      if (c_tag_ff.kind == tfp_pkg::KIND_CHARGE) begin
         d_q_in = c_m_ff;
         d_r_in = '0;
      end else if (d_r0 >= d_div) begin
         d_q_in = c_e_ff + 32'd1;
         d_r_in = 24'(d_r0 - d_div);
      end else begin
         d_q_in = c_e_ff;
         d_r_in = d_r0[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         d_tag_ff <= c_tag_ff;
         d_q_ff   <= d_q_in;
         d_r_ff   <= d_r_in;
      end
   end

   // Stage E: remainder times the fine reciprocal
   assign e_prod_in = 49'(d_r_ff) * 49'(tfp_pkg::recip_fine(d_tag_ff.kind));

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         e_tag_ff  <= d_tag_ff;
         e_q_ff    <= d_q_ff;
         e_r_ff    <= d_r_ff;
         e_prod_ff <= e_prod_in;
      end
   end

   // Stage F: second estimate (minutes or Q24 fraction) and back product
   always_comb begin
      unique case (e_tag_ff.kind)
         tfp_pkg::KIND_UPTIME:   f_shift = e_prod_ff >> tfp_pkg::FSHIFT_MIN;
         tfp_pkg::KIND_VOLTS,
         tfp_pkg::KIND_CHARGE:   f_shift = e_prod_ff >> tfp_pkg::FSHIFT_TENTH;
         tfp_pkg::KIND_LON,
         tfp_pkg::KIND_LAT:      f_shift = e_prod_ff >> tfp_pkg::FSHIFT_GEO;
         tfp_pkg::KIND_ROLL, tfp_pkg::KIND_PITCH,
         tfp_pkg::KIND_NET:      f_shift = e_prod_ff >> tfp_pkg::FSHIFT_HUND;
      endcase
      f_e2_in  = f_shift[23:0];
      f_e2d_in = 48'(f_e2_in) * 48'(tfp_pkg::div_fine(e_tag_ff.kind));
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         f_tag_ff <= e_tag_ff;
         f_q_ff   <= e_q_ff;
         f_r_ff   <= e_r_ff;
         f_e2_ff  <= f_e2_in;
         f_e2d_ff <= f_e2d_in;
      end
   end

   // Stage G: correct the fraction, join integer and fraction, split seconds
   always_comb begin
      g_diff = {f_r_ff, 24'd0} - f_e2d_ff;
      if (f_tag_ff.kind == tfp_pkg::KIND_CHARGE) begin
         g_frac = '0;
      end else if (g_diff >= 48'(tfp_pkg::div_coarse(f_tag_ff.kind))) begin
         g_frac = f_e2_ff + 24'd1;
      end else begin
         g_frac = f_e2_ff;
      end
      g_mag_in   = {f_q_ff, g_frac};
      g_hours_in = f_q_ff[19:0];
      g_min_in   = f_e2_ff[5:0];
      g_sec_full = f_r_ff - f_e2d_ff[23:0];
      g_sec_in   = g_sec_full[5:0];
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         g_tag_ff   <= f_tag_ff;
         g_mag_ff   <= g_mag_in;
         g_hours_ff <= g_hours_in;
         g_min_ff   <= g_min_in;
         g_sec_ff   <= g_sec_in;
      end
   end

   // Stage H: apply sign, zero the fields that do not belong to the kind
   always_comb begin
      h_up    = (g_tag_ff.kind == tfp_pkg::KIND_UPTIME);
      h_hours = {1'b0, g_hours_ff};
      h_min   = {1'b0, g_min_ff};
      h_sec   = {1'b0, g_sec_ff};
      out_kind_in = g_tag_ff.kind;
      out_raw_in  = g_tag_ff.raw;
      out_done_in = g_tag_ff.done;
      if (h_up) begin
         out_scaled_in = '0;
         out_hours_in  = signed'(g_tag_ff.neg ? (~h_hours + 21'd1) : h_hours);
         out_min_in    = signed'(g_tag_ff.neg ? (~h_min + 7'd1) : h_min);
         out_sec_in    = signed'(g_tag_ff.neg ? (~h_sec + 7'd1) : h_sec);
      end else begin
         out_scaled_in = signed'(g_tag_ff.neg ? (~g_mag_ff + 56'd1) : g_mag_ff);
         out_hours_in  = '0;
         out_min_in    = '0;
         out_sec_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         out_kind_ff   <= out_kind_in;
         out_raw_ff    <= out_raw_in;
         out_scaled_ff <= out_scaled_in;
         out_hours_ff  <= out_hours_in;
         out_min_ff    <= out_min_in;
         out_sec_ff    <= out_sec_in;
         out_done_ff   <= out_done_in;
      end
   end

   assign rsp_if.valid          = vld_ff[7];
   assign rsp_if.field_kind     = out_kind_ff;
   assign rsp_if.raw_value      = out_raw_ff;
   assign rsp_if.scaled_value   = out_scaled_ff;
   assign rsp_if.uptime_hours   = out_hours_ff;
   assign rsp_if.uptime_minutes = out_min_ff;
   assign rsp_if.uptime_seconds = out_sec_ff;
   assign rsp_if.message_done   = out_done_ff;

`ifndef SYNTH
   // Corrected remainder of the integer split stays below its divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[3] && (d_tag_ff.kind != tfp_pkg::KIND_CHARGE))
      |-> (d_r_ff < tfp_pkg::div_coarse(d_tag_ff.kind)))
      else $error("integer split remainder out of range");

   // Minutes and seconds magnitudes stay below sixty
   a_clock_bound: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[6] && (g_tag_ff.kind == tfp_pkg::KIND_UPTIME))
      |-> ((g_min_ff < 6'd60) && (g_sec_ff < 6'd60)))
      else $error("uptime minutes or seconds out of range");

   // Hours, minutes and seconds add back up to the raw uptime
   a_uptime_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (rsp_if.field_kind == tfp_pkg::KIND_UPTIME))
      |-> ((32'(rsp_if.uptime_hours) * 32'sd3600 + 32'(rsp_if.uptime_minutes) * 32'sd60
            + 32'(rsp_if.uptime_seconds)) == rsp_if.raw_value))
      else $error("uptime split does not match raw value");
`endif

endmodule
